FILE: sv/xalu_pkg.sv
// Shared constants and types for the x86 integer ALU with flags.
`default_nettype none

package xalu_pkg;

    localparam int unsigned DATA_W = 32;

    // operation codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_OR  = 4'd1;
    localparam logic [3:0] OP_ADC = 4'd2;
    localparam logic [3:0] OP_SBB = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_SUB = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_INC = 4'd8;
    localparam logic [3:0] OP_DEC = 4'd9;
    localparam logic [3:0] OP_NOT = 4'd10;
    localparam logic [3:0] OP_NEG = 4'd11;

    // operand size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;

    // flag masks
    localparam logic [DATA_W-1:0] FLAG_CF  = 32'h0000_0001;
    localparam logic [DATA_W-1:0] FLAG_PF  = 32'h0000_0004;
    localparam logic [DATA_W-1:0] FLAG_AF  = 32'h0000_0010;
    localparam logic [DATA_W-1:0] FLAG_ZF  = 32'h0000_0040;
    localparam logic [DATA_W-1:0] FLAG_SF  = 32'h0000_0080;
    localparam logic [DATA_W-1:0] FLAG_OF  = 32'h0000_0800;
    localparam logic [DATA_W-1:0] FLAG_ALL =
        FLAG_CF | FLAG_PF | FLAG_AF | FLAG_ZF | FLAG_SF | FLAG_OF;

    // what the middle stage does with the operands
    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_PASS,
        KIND_NOT
    } t_kind;

    // result status bits
    typedef struct packed {
        logic pf;
        logic zf;
        logic sf;
    } t_status;

endpackage

`default_nettype wire

FILE: sv/xalu_if.sv
// Request and response channel interfaces of the ALU.
`default_nettype none

interface xalu_req_if;
    logic                       valid;
    logic                       ready;
    logic [3:0]                 req_type;
    logic [xalu_pkg::DATA_W-1:0] operand_a;
    logic [xalu_pkg::DATA_W-1:0] operand_b;
    logic [1:0]                 operand_size;
    logic [xalu_pkg::DATA_W-1:0] flags_in;

    modport source (
        output valid, req_type, operand_a, operand_b, operand_size, flags_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, operand_a, operand_b, operand_size, flags_in,
        output ready
    );
endinterface

interface xalu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [xalu_pkg::DATA_W-1:0] result;
    logic [xalu_pkg::DATA_W-1:0] flags_out;

    modport source (
        output valid, result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result, flags_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/x86_alu_with_flags.sv
// x86 integer ALU with flags, three-stage pipeline.
//
//  Channel | Dir | Fields                                              | Handshake
//  i_req   | in  | req_type operand_a operand_b operand_size flags_in | valid/ready
//  o_rsp   | out | result flags_out                                    | valid/ready
//
//  One request per cycle sustained while o_rsp is ready; each request is registered
//  through the decode, add/subtract and flag assembly stages in that order before
//  its result is presented on o_rsp.
//  Reset clears the stage valid bits only; no clearing pass.
//  A stall on o_rsp holds each occupied stage; an empty stage still fills,
//  so i_req.ready drops only once all three stages are occupied and o_rsp stalls.
`default_nettype none

module x86_alu_with_flags (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    xalu_req_if.sink   i_req,
    xalu_rsp_if.source o_rsp
);
    import xalu_pkg::*;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic w_adv1, w_adv2, w_adv3;

    // stage 1: decoded operands
    t_kind              r_kind1, n_kind1;
    logic [DATA_W-1:0]  r_x1, n_x1;
    logic [DATA_W-1:0]  r_y1, n_y1;
    logic               r_c1, n_c1;
    logic               r_keep1, n_keep1;
    logic [DATA_W-1:0]  r_wmask1, n_wmask1;
    logic [DATA_W-1:0]  r_top1, n_top1;
    logic [DATA_W-1:0]  r_fin1;

    // stage 2: result and carry
    t_kind              r_kind2;
    logic [DATA_W-1:0]  r_x2, r_y2;
    logic [DATA_W-1:0]  r_res2, n_res2;
    logic               r_cf2, n_cf2;
    logic               r_keep2;
    logic [DATA_W-1:0]  r_wmask2;
    logic [DATA_W-1:0]  r_top2;
    logic [DATA_W-1:0]  r_fin2;

    // stage 3: output registers
    logic [DATA_W-1:0]  r_res3;
    logic [DATA_W-1:0]  r_flags3, n_flags3;

    logic [DATA_W-1:0]  w_a_m, w_b_m;
    logic [DATA_W:0]    w_sum, w_diff;
    logic               w_cf, w_of, w_af;
    t_status            w_status;

    assign w_adv3      = !r_v3 || o_rsp.ready;
    assign w_adv2      = !r_v2 || w_adv3;
    assign w_adv1      = !r_v1 || w_adv2;
    assign i_req.ready = w_adv1;

    // ---------------- stage 1: mask and decode ----------------
    always_comb begin
        case (i_req.operand_size)
            SZ_BYTE: begin
                n_wmask1 = 32'h0000_00ff;
                n_top1   = 32'h0000_0080;
            end
            SZ_WORD: begin
                n_wmask1 = 32'h0000_ffff;
                n_top1   = 32'h0000_8000;
            end
            default: begin
                n_wmask1 = 32'hffff_ffff;
                n_top1   = 32'h8000_0000;
            end
        endcase

        w_a_m   = i_req.operand_a & n_wmask1;
        w_b_m   = i_req.operand_b & n_wmask1;
        n_kind1 = KIND_PASS;
        n_x1    = '0;
        n_y1    = '0;
        n_c1    = 1'b0;
        n_keep1 = 1'b0;

        case (i_req.req_type)
            OP_ADD: begin
                n_kind1 = KIND_ADD;
                n_x1    = w_a_m;
                n_y1    = w_b_m;
            end
            OP_ADC: begin
                n_kind1 = KIND_ADD;
                n_x1    = w_a_m;
                n_y1    = w_b_m;
                n_c1    = i_req.flags_in[0];
            end
            OP_INC: begin
                n_kind1 = KIND_ADD;
                n_x1    = w_a_m;
                n_y1    = DATA_W'(1);
                n_keep1 = 1'b1;
            end
            OP_SUB: begin
                n_kind1 = KIND_SUB;
                n_x1    = w_a_m;
                n_y1    = w_b_m;
            end
            OP_SBB: begin
                n_kind1 = KIND_SUB;
                n_x1    = w_a_m;
                n_y1    = w_b_m;
                n_c1    = i_req.flags_in[0];
            end
            OP_DEC: begin
                n_kind1 = KIND_SUB;
                n_x1    = w_a_m;
                n_y1    = DATA_W'(1);
                n_keep1 = 1'b1;
            end
            OP_NEG: begin
                n_kind1 = KIND_SUB;
                n_y1    = w_a_m;
            end
            OP_OR:  n_x1 = w_a_m | w_b_m;
            OP_AND: n_x1 = w_a_m & w_b_m;
            OP_XOR: n_x1 = w_a_m ^ w_b_m;
            OP_NOT: begin
                n_kind1 = KIND_NOT;
                n_x1    = ~w_a_m & n_wmask1;
            end
            // reserved codes give zero with zero-result flags
            default: n_x1 = '0;
        endcase
    end

    // ---------------- stage 2: add or subtract ----------------
    always_comb begin
        w_sum  = {1'b0, r_x1} + {1'b0, r_y1} + {{DATA_W{1'b0}}, r_c1};
        w_diff = {1'b0, r_x1} - {1'b0, r_y1} - {{DATA_W{1'b0}}, r_c1};
        case (r_kind1)
            KIND_ADD: begin
                n_res2 = w_sum[DATA_W-1:0] & r_wmask1;
                // any bit above the size mask is a carry out
                n_cf2  = |(w_sum & ~{1'b0, r_wmask1});
            end
            KIND_SUB: begin
                n_res2 = w_diff[DATA_W-1:0] & r_wmask1;
                n_cf2  = w_diff[DATA_W];
            end
            default: begin
                n_res2 = r_x1;
                n_cf2  = 1'b0;
            end
        endcase
    end

    // ---------------- stage 3: flags ----------------
    xalu_status u_status (
        .i_res    (r_res2),
        .i_top    (r_top2),
        .o_status (w_status)
    );

    always_comb begin
        w_of = 1'b0;
        w_af = 1'b0;
        w_cf = r_keep2 ? r_fin2[0] : r_cf2;
        case (r_kind2)
            KIND_ADD: begin
                w_of = |(~(r_x2 ^ r_y2) & (r_x2 ^ r_res2) & r_top2);
                w_af = |((r_x2 ^ r_y2 ^ r_res2) & FLAG_AF);
            end
            KIND_SUB: begin
                w_of = |((r_x2 ^ r_y2) & (r_x2 ^ r_res2) & r_top2);
                w_af = |((r_x2 ^ r_y2 ^ r_res2) & FLAG_AF);
            end
            default: begin
                w_of = 1'b0;
                w_af = 1'b0;
            end
        endcase

        if (r_kind2 == KIND_NOT) begin
            n_flags3 = r_fin2;
        end else begin
            n_flags3 = (r_fin2 & ~FLAG_ALL)
                     | (w_cf        ? FLAG_CF : '0)
                     | (w_status.pf ? FLAG_PF : '0)
                     | (w_af        ? FLAG_AF : '0)
                     | (w_status.zf ? FLAG_ZF : '0)
                     | (w_status.sf ? FLAG_SF : '0)
                     | (w_of        ? FLAG_OF : '0);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_req.valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_kind1  <= n_kind1;
            r_x1     <= n_x1;
            r_y1     <= n_y1;
            r_c1     <= n_c1;
            r_keep1  <= n_keep1;
            r_wmask1 <= n_wmask1;
            r_top1   <= n_top1;
            r_fin1   <= i_req.flags_in;
        end
        if (w_adv2) begin
            r_kind2  <= r_kind1;
            r_x2     <= r_x1;
            r_y2     <= r_y1;
            r_res2   <= n_res2;
            r_cf2    <= n_cf2;
            r_keep2  <= r_keep1;
            r_wmask2 <= r_wmask1;
            r_top2   <= r_top1;
            r_fin2   <= r_fin1;
        end
        if (w_adv3) begin
            r_res3   <= r_res2;
            r_flags3 <= n_flags3;
        end
    end

    assign o_rsp.valid     = r_v3;
    assign o_rsp.result    = r_res3;
    assign o_rsp.flags_out = r_flags3;

    // ---------------- assertions ----------------
    a_res_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_adv3) |=> ((r_res3 & ~$past(r_wmask2)) == '0))
        else $error("result has bits above the operand size");

    a_flags_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_adv3) |=> (((r_flags3 ^ $past(r_fin2)) & ~FLAG_ALL) == '0))
        else $error("non-status flag bits changed");

    a_logic_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_adv3 && r_kind2 == KIND_PASS)
        |=> ((r_flags3 & (FLAG_CF | FLAG_OF | FLAG_AF)) == '0))
        else $error("logical operation left CF, OF or AF set");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_adv3) |=> (r_v2 && $stable(r_res2) && $stable(r_fin2)))
        else $error("stalled middle stage lost its request");

endmodule

`default_nettype wire

FILE: sv/xalu_status.sv
// Parity, zero and sign flags of a masked result.
`default_nettype none

module xalu_status (
    input  wire logic [xalu_pkg::DATA_W-1:0] i_res,
    input  wire logic [xalu_pkg::DATA_W-1:0] i_top,
    output xalu_pkg::t_status                o_status
);
    import xalu_pkg::*;

    always_comb begin
        // parity looks at the low byte only, set when even
        o_status.pf = ~(^i_res[7:0]);
        o_status.zf = (i_res == '0);
        o_status.sf = |(i_res & i_top);
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_x86_alu_with_flags.sv
// Self-checking testbench for the x86 integer ALU with flags.
`default_nettype none

module tb_x86_alu_with_flags;
    timeunit 1ns;
    timeprecision 1ps;

    import xalu_pkg::*;

    // codes the package leaves unnamed
    localparam logic [3:0] OP_RSVD7  = 4'd7;
    localparam logic [3:0] OP_RSVD12 = 4'd12;
    localparam logic [3:0] OP_RSVD15 = 4'd15;
    localparam logic [1:0] SZ_DWORD  = 2'd2;
    localparam logic [1:0] SZ_WIDE   = 2'd3;

    localparam int N_DIRECTED     = 24;
    localparam int ITEMS_PER_MIX  = 500;
    localparam int N_MIXES        = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 400_000;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] flags;
    } t_alu_out;

    typedef struct packed {
        logic [3:0]        op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [1:0]        size;
        logic [DATA_W-1:0] flags;
        logic              known;
        logic [DATA_W-1:0] want_result;
        logic [DATA_W-1:0] want_flags;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    xalu_req_if req_if ();
    xalu_rsp_if rsp_if ();

    x86_alu_with_flags u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    t_alu_out due_results[$];
    int       send_idle_pct = 0;
    int       rsp_stall_pct = 0;
    int       n_sent        = 0;
    int       n_checked     = 0;
    int       n_mismatch    = 0;
    int       n_carry_out   = 0;
    int       n_overflow    = 0;
    int       cycle_count   = 0;

    // extremes, every operation and the odd codes; typed values only where obvious
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{OP_NOT,    32'h0000_0000, 32'hFFFF_FFFF, SZ_BYTE,  32'hFFFF_FFFF,
          1'b1, 32'h0000_00FF, 32'hFFFF_FFFF},
        '{OP_RSVD7,  32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_DWORD, 32'hFFFF_FFFF,
          1'b1, 32'h0000_0000, 32'hFFFF_F76E},
        '{OP_RSVD15, 32'h1234_5678, 32'h9ABC_DEF0, SZ_BYTE,  32'h0000_0000,
          1'b1, 32'h0000_0000, 32'h0000_0044},
        '{OP_RSVD12, 32'h0000_FFFF, 32'h0000_0001, SZ_WORD,  32'h0000_08D5,
          1'b1, 32'h0000_0000, 32'h0000_0044},
        '{OP_ADD,    32'hFFFF_FFFF, 32'h0000_0001, SZ_DWORD, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'h0000_0055},
        '{OP_ADD,    32'hABCD_EF7F, 32'h1234_5601, SZ_BYTE,  32'h0000_0000,
          1'b1, 32'h0000_0080, 32'h0000_0890},
        '{OP_SUB,    32'hFFFF_0000, 32'h0000_0001, SZ_WORD,  32'h0000_0000,
          1'b1, 32'h0000_FFFF, 32'h0000_0095},
        '{OP_NEG,    32'h8000_0000, 32'h0000_0000, SZ_DWORD, 32'h0000_0000,
          1'b1, 32'h8000_0000, 32'h0000_0885},
        '{OP_NEG,    32'h0000_0100, 32'hFFFF_FFFF, SZ_BYTE,  32'hFFFF_FFFF,
          1'b1, 32'h0000_0000, 32'hFFFF_F76E},
        '{OP_OR,     32'h0000_0000, 32'h0000_0000, SZ_DWORD, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{OP_AND,    32'h0000_00FF, 32'h0000_00FF, SZ_BYTE,  32'h0000_08D5,
          1'b0, 32'h0, 32'h0},
        '{OP_XOR,    32'h0000_FFFF, 32'h0000_FFFF, SZ_WORD,  32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{OP_ADC,    32'h0000_00FF, 32'h0000_0000, SZ_BYTE,  32'h0000_0001,
          1'b0, 32'h0, 32'h0},
        '{OP_ADC,    32'h7FFF_FFFF, 32'h0000_0000, SZ_DWORD, 32'h0000_0001,
          1'b0, 32'h0, 32'h0},
        '{OP_SBB,    32'h0000_0000, 32'h0000_0000, SZ_WORD,  32'h0000_0001,
          1'b0, 32'h0, 32'h0},
        '{OP_SBB,    32'h0000_0080, 32'h0000_007F, SZ_BYTE,  32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{OP_INC,    32'h0000_00FF, 32'h0000_0000, SZ_BYTE,  32'h0000_0001,
          1'b0, 32'h0, 32'h0},
        '{OP_INC,    32'h0000_7FFF, 32'h0000_0000, SZ_WORD,  32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{OP_DEC,    32'h0000_0000, 32'h0000_0000, SZ_DWORD, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{OP_DEC,    32'h0000_0080, 32'h0000_0000, SZ_BYTE,  32'h0000_0001,
          1'b0, 32'h0, 32'h0},
        '{OP_SUB,    32'h8000_0000, 32'h0000_0001, SZ_DWORD, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{OP_NOT,    32'h1234_5678, 32'h0000_0000, SZ_WIDE,  32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_WIDE,  32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{OP_XOR,    32'h0000_00AA, 32'h0000_0055, SZ_BYTE,  32'h0000_0000,
          1'b0, 32'h0, 32'h0}
    };

    function automatic t_alu_out compute_alu_op(input t_stim_row req);
        logic [DATA_W-1:0] wmask, top, a, b, x, y, res, status;
        logic [DATA_W:0]   wide;
        logic              cin, c, is_add, is_sub;
        t_alu_out          out;
        case (req.size)
            SZ_BYTE: wmask = 32'h0000_00FF;
            SZ_WORD: wmask = 32'h0000_FFFF;
            default: wmask = 32'hFFFF_FFFF;
        endcase
        top    = wmask ^ (wmask >> 1);
        a      = req.a & wmask;
        b      = req.b & wmask;
        cin    = (req.flags & FLAG_CF) != 0;
        is_add = 1'b0;
        is_sub = 1'b0;
        x      = '0;
        y      = '0;
        c      = 1'b0;
        res    = '0;
        status = '0;
        case (req.op)
            OP_OR:  res = a | b;
            OP_AND: res = a & b;
            OP_XOR: res = a ^ b;
            OP_NOT: begin
                // flags pass through untouched
                out.result = ~a & wmask;
                out.flags  = req.flags;
                return out;
            end
            OP_ADD: begin is_add = 1'b1; x = a; y = b; end
            OP_ADC: begin is_add = 1'b1; x = a; y = b; c = cin; end
            OP_INC: begin is_add = 1'b1; x = a; y = 32'd1; end
            OP_SUB: begin is_sub = 1'b1; x = a; y = b; end
            OP_SBB: begin is_sub = 1'b1; x = a; y = b; c = cin; end
            OP_DEC: begin is_sub = 1'b1; x = a; y = 32'd1; end
            OP_NEG: begin is_sub = 1'b1; x = '0; y = a; end
            default: res = '0;
        endcase
        if (is_add) begin
            wide = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, c};
            res  = wide[DATA_W-1:0] & wmask;
            if (wide > {1'b0, wmask}) status |= FLAG_CF;
            if ((~(x ^ y) & (x ^ res) & top) != 0) status |= FLAG_OF;
            status |= (x ^ y ^ res) & FLAG_AF;
        end else if (is_sub) begin
            res = (x - y - {{(DATA_W-1){1'b0}}, c}) & wmask;
            if (({1'b0, y} + {{DATA_W{1'b0}}, c}) > {1'b0, x}) status |= FLAG_CF;
            if (((x ^ y) & (x ^ res) & top) != 0) status |= FLAG_OF;
            status |= (x ^ y ^ res) & FLAG_AF;
        end
        // parity looks at the low byte only
        if (~^res[7:0]) status |= FLAG_PF;
        if (res == 0) status |= FLAG_ZF;
        if ((res & top) != 0) status |= FLAG_SF;
        if (req.op == OP_INC || req.op == OP_DEC)
            status = (status & ~FLAG_CF) | (req.flags & FLAG_CF);
        out.result = res;
        out.flags  = (req.flags & ~FLAG_ALL) | status;
        return out;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        v = $urandom;
        // lean on sign and carry boundaries, keep random upper bits
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v[7:0]  = $urandom_range(1) ? 8'h80 : 8'h7F;
            3: v[15:0] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            4: v       = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] pick_op();
        logic [3:0] op;
        case ($urandom_range(11))
            0:  op = OP_ADD;
            1:  op = OP_OR;
            2:  op = OP_ADC;
            3:  op = OP_SBB;
            4:  op = OP_AND;
            5:  op = OP_SUB;
            6:  op = OP_XOR;
            7:  op = OP_INC;
            8:  op = OP_DEC;
            9:  op = OP_NOT;
            10: op = OP_NEG;
            default: op = 4'($urandom_range(15));
        endcase
        return op;
    endfunction

    function automatic void log_mismatch(input string what, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s: expected %08h, got %08h", $realtime, what, want, got);
    endfunction

    task automatic send_request(input t_stim_row req);
        // hold the channel idle for a random while
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= req.op;
        req_if.operand_a    <= req.a;
        req_if.operand_b    <= req.b;
        req_if.operand_size <= req.size;
        req_if.flags_in     <= req.flags;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        if (req.known)
            due_results.push_back(t_alu_out'{req.want_result, req.want_flags});
        else
            due_results.push_back(compute_alu_op(req));
        n_sent++;
    endtask

    task automatic wait_drained();
        while (due_results.size() != 0) @(posedge clk);
    endtask

    // response side: check on handshake, then redraw ready
    initial begin
        t_alu_out due;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (due_results.size() == 0) begin
                    log_mismatch("unexpected result", 'x, rsp_if.result);
                end else begin
                    due = due_results.pop_front();
                    if (rsp_if.result !== due.result)
                        log_mismatch("result", due.result, rsp_if.result);
                    if (rsp_if.flags_out !== due.flags)
                        log_mismatch("flags_out", due.flags, rsp_if.flags_out);
                    n_checked++;
                    if ((due.flags & FLAG_CF) != 0) n_carry_out++;
                    if ((due.flags & FLAG_OF) != 0) n_overflow++;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_stim_row req;
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= OP_ADD;
        req_if.operand_a    <= '0;
        req_if.operand_b    <= '0;
        req_if.operand_size <= SZ_BYTE;
        req_if.flags_in     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int mix = 0; mix < N_MIXES; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 84; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 84; end
                default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
            endcase
            if (mix == 0) begin
                foreach (directed_rows[i]) send_request(directed_rows[i]);
            end
            repeat (ITEMS_PER_MIX) begin
                req.op          = pick_op();
                req.a           = pick_operand();
                req.b           = pick_operand();
                req.size        = ($urandom_range(9) == 0) ? SZ_WIDE : 2'($urandom_range(2));
                req.flags       = $urandom;
                req.known       = 1'b0;
                req.want_result = '0;
                req.want_flags  = '0;
                send_request(req);
            end
            // drop valid and let the pipeline empty before the next mix
            req_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("%0d requests (%0d directed) over four handshake mixes, %0d results checked",
                 n_sent, N_DIRECTED, n_checked);
        $display("%0d results carried out, %0d overflowed", n_carry_out, n_overflow);
        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", n_mismatch);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
